>>> rtl/core/med3x3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// med3x3_pkg
// shared types, constants and the nine-input median network for the 3x3
// median filter
// ----------------------------------------------------------------------------
package med3x3_pkg;

	localparam int PIX_W          = 32;
	localparam int CFG_W          = 12;
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;
	localparam int WIDTH_RESET    = 640;
	localparam int HEIGHT_RESET   = 480;
	localparam int WIN_N          = 9;
	localparam int MED_IDX        = 4;
	localparam int FIFO_DEPTH     = 8;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

	typedef enum logic [0:0] {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	// stage 1 control
	typedef struct packed {
		logic valid;
		logic is_flush;
		logic emit;
		logic interior;
		logic last;
		logic use_win7;
	} s1_ctl_t;

	// sort pipeline tag
	typedef struct packed {
		logic   valid;
		logic   interior;
		logic   last;
		pixel_t pass;
	} tag_t;

	typedef struct packed {
		pixel_t pixel;
		logic   last;
	} out_t;

	// compare-exchange network for the median of nine, grouped in layers
	localparam int NET_N = 19;
	localparam int NET_A [NET_N] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
	localparam int NET_B [NET_N] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};
	localparam int NET_L [NET_N] = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3, 4, 4, 4, 5, 6, 7, 8};

	function automatic win_t net_layers(input win_t v, input int first, input int last);
		win_t   r;
		pixel_t lo;
		pixel_t hi;
		r = v;
		for (int i = 0; i < NET_N; i++) begin
			if (NET_L[i] >= first && NET_L[i] <= last) begin
				lo = (r[NET_A[i]] > r[NET_B[i]]) ? r[NET_B[i]] : r[NET_A[i]];
				hi = (r[NET_A[i]] > r[NET_B[i]]) ? r[NET_A[i]] : r[NET_B[i]];
				r[NET_A[i]] = lo;
				r[NET_B[i]] = hi;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/med3x3_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// med3x3_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module med3x3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/median_3x3_image_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// median_3x3_image_filter
// 3x3 median filter over a raster stream of 32-bit pixel words
// ----------------------------------------------------------------------------
// input stream: s_tdata carries a pixel, s_tuser selects pixel (0) or flush (1).
// output stream: m_tdata is the filtered pixel, m_tlast marks the last pixel
// of the frame. each output lags its input by one row and one column; after
// the last pixel of a frame, flush transfers drain the remaining outputs.
// interior pixels take the median of their 3x3 neighborhood ranked as whole
// unsigned words, border pixels pass through.
// cfg_we/cfg_index/cfg_data write image width (0) or height (1) and restart
// the frame; write only while the block is idle.
// throughput: one transfer per clock while s_tready is high. a result passes
// through the line buffer read, the window update, four stages of the median
// network and a write into an 8-deep output fifo before it reaches the
// output.
// s_tready drops when eight results are in flight or waiting, so a stalled
// receiver backs up the input without losing anything.
// reset: 640x480, counters and window cleared; line buffers are not cleared.
// ----------------------------------------------------------------------------
module median_3x3_image_filter #(
	parameter int MAX_WIDTH  = med3x3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = med3x3_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [31:0]                       s_tdata,   // [31:0] pixel_in
	input  wire logic [0:0]                        s_tuser,   // [0] op
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [31:0]                       m_tdata,   // [31:0] pixel_out
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire med3x3_pkg::cfg_idx_t              cfg_index,
	input  wire logic [med3x3_pkg::CFG_W-1:0]      cfg_data
);

	import med3x3_pkg::*;

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int TW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int FPW  = $clog2(FIFO_DEPTH);

	// configuration and frame position
	logic [CFG_W-1:0] cfg_w_q;
	logic [CFG_W-1:0] cfg_h_q;
	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic [WW+HW-1:0] prod;
	logic [TW-1:0]    total_q;
	logic [AW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [CNTW-1:0]  out_cnt_q;
	logic             frame_done_q;

	// stream control
	op_t              op;
	logic             acc;
	logic             pix_acc;
	logic             fl_acc;
	logic             emit;
	logic             interior;
	logic             col_last;
	logic             row_last;
	logic [TW:0]      o_plus_w;
	logic             use_win7;
	logic             fl_last;
	logic [AW-1:0]    fl_col;
	logic [AW-1:0]    rd_addr;
	logic             produce;

	// stage 1
	s1_ctl_t          ctl_s1;
	pixel_t           pix_s1;
	logic [AW-1:0]    addr_s1;
	pixel_t           up_rdata;
	pixel_t           mid_rdata;
	pixel_t           up_fwd;
	pixel_t           mid_fwd;
	logic             ram_we;
	logic             fwd_vld_q;
	logic [AW-1:0]    fwd_addr_q;
	pixel_t           fwd_up_q;
	pixel_t           fwd_mid_q;
	win_t             win_q;
	win_t             win_next;

	// median pipeline
	win_t             win_s2;
	win_t             win_s3;
	win_t             win_s4;
	win_t             win_s5;
	win_t             win_s6;
	tag_t             tag_s2;
	tag_t             tag_s3;
	tag_t             tag_s4;
	tag_t             tag_s5;
	tag_t             tag_s6;
	win_t             win_fin;
	out_t             push_data;

	// output fifo
	out_t             fifo_q [FIFO_DEPTH];
	logic [FPW-1:0]   wr_ptr_q;
	logic [FPW-1:0]   rd_ptr_q;
	logic [FPW:0]     fifo_cnt_q;
	logic [FPW:0]     pending_q;
	logic             push;
	logic             pop;

	// effective frame size
	always_comb begin
		if (cfg_w_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg_h_q);
		end
	end

	assign prod = (WW+HW)'(w_eff) * (WW+HW)'(h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else begin
			total_q <= TW'(prod);
		end
	end

	// input decode
	assign op       = op_t'(s_tuser);
	assign s_tready = (pending_q != (FPW+1)'(FIFO_DEPTH));
	assign acc      = s_tvalid && s_tready;
	assign pix_acc  = acc && (op == OP_PIXEL) && !frame_done_q;
	assign fl_acc   = acc && (op == OP_FLUSH) && frame_done_q;

	assign emit     = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
	assign interior = (row_q >= RW'(2)) && (col_q >= AW'(2));
	assign col_last = ((WW'(col_q) + WW'(1)) == w_eff);
	assign row_last = ((HW'(row_q) + HW'(1)) == h_eff);

	assign o_plus_w = (TW+1)'(out_cnt_q) + (TW+1)'(w_eff);
	assign use_win7 = (o_plus_w < (TW+1)'(total_q));
	assign fl_col   = AW'(o_plus_w - (TW+1)'(total_q));
	assign fl_last  = ((TW'(out_cnt_q) + TW'(1)) == total_q);
	assign rd_addr  = (op == OP_FLUSH) ? fl_col : col_q;
	assign produce  = fl_acc || (pix_acc && emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q      <= CFG_W'(WIDTH_RESET);
			cfg_h_q      <= CFG_W'(HEIGHT_RESET);
			col_q        <= '0;
			row_q        <= '0;
			out_cnt_q    <= '0;
			frame_done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH:  cfg_w_q <= cfg_data;
					CFG_IMAGE_HEIGHT: cfg_h_q <= cfg_data;
					default:          cfg_w_q <= cfg_w_q;
				endcase
				col_q        <= '0;
				row_q        <= '0;
				out_cnt_q    <= '0;
				frame_done_q <= 1'b0;
			end else if (pix_acc) begin
				if (col_last) begin
					col_q <= '0;
					if (row_last) begin
						frame_done_q <= 1'b1;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + AW'(1);
				end
				if (emit) begin
					out_cnt_q <= out_cnt_q + CNTW'(1);
				end
			end else if (fl_acc) begin
				if (fl_last) begin
					col_q        <= '0;
					row_q        <= '0;
					out_cnt_q    <= '0;
					frame_done_q <= 1'b0;
				end else begin
					out_cnt_q <= out_cnt_q + CNTW'(1);
				end
			end
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid    <= pix_acc || fl_acc;
			ctl_s1.is_flush <= fl_acc;
			ctl_s1.emit     <= emit;
			ctl_s1.interior <= interior;
			ctl_s1.last     <= fl_last;
			ctl_s1.use_win7 <= use_win7;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1  <= s_tdata;
		addr_s1 <= rd_addr;
	end

	// line buffers
	assign ram_we = ctl_s1.valid && !ctl_s1.is_flush;

	med3x3_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_ram_upper (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(mid_fwd),
		.raddr(rd_addr),
		.rdata(up_rdata)
	);

	med3x3_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_ram_middle (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(pix_s1),
		.raddr(rd_addr),
		.rdata(mid_rdata)
	);

	// write in the read cycle is not seen by the ram, forward it
	assign up_fwd  = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_up_q : up_rdata;
	assign mid_fwd = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_mid_q : mid_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_up_q   <= mid_fwd;
		fwd_mid_q  <= pix_s1;
	end

	// window shift
	always_comb begin
		for (int i = 0; i < WIN_N - 3; i++) begin
			win_next[i] = win_q[i+3];
		end
		win_next[WIN_N-3] = up_fwd;
		win_next[WIN_N-2] = mid_fwd;
		win_next[WIN_N-1] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ram_we) begin
			win_q <= win_next;
		end
	end

	// median network pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else begin
			tag_s2.valid    <= ctl_s1.valid && (ctl_s1.is_flush || ctl_s1.emit);
			tag_s2.interior <= !ctl_s1.is_flush && ctl_s1.interior;
			tag_s2.last     <= ctl_s1.is_flush && ctl_s1.last;
			tag_s2.pass     <= (ctl_s1.is_flush && !ctl_s1.use_win7) ? mid_fwd : win_q[7];
			tag_s3          <= tag_s2;
			tag_s4          <= tag_s3;
			tag_s5          <= tag_s4;
			tag_s6          <= tag_s5;
		end
	end

	always_ff @(posedge clk) begin
		win_s2 <= win_next;
		win_s3 <= net_layers(win_s2, 0, 1);
		win_s4 <= net_layers(win_s3, 2, 3);
		win_s5 <= net_layers(win_s4, 4, 5);
		win_s6 <= net_layers(win_s5, 6, 7);
	end

	assign win_fin         = net_layers(win_s6, 8, 8);
	assign push            = tag_s6.valid;
	assign push_data.pixel = tag_s6.interior ? win_fin[MED_IDX] : tag_s6.pass;
	assign push_data.last  = tag_s6.last;

	// output fifo
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (fifo_cnt_q != '0);
	assign m_tdata  = fifo_q[rd_ptr_q].pixel;
	assign m_tlast  = fifo_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			pending_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FPW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + (FPW+1)'(push) - (FPW+1)'(pop);
			pending_q  <= pending_q + (FPW+1)'(produce) - (FPW+1)'(pop);
		end
	end

	// checks
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= (FPW+1)'(FIFO_DEPTH))
		else $error("results in flight exceed fifo depth");

	a_fifo_in_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= pending_q)
		else $error("fifo holds more than the credited results");

	a_flush_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fl_acc && fl_last && !cfg_we) |=> (out_cnt_q == '0 && !frame_done_q && col_q == '0))
		else $error("frame did not restart after final flush");

	a_no_pixel_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_done_q && !cfg_we && !fl_acc) |=> (frame_done_q && $stable(out_cnt_q)))
		else $error("frame state moved without a flush");

endmodule
`default_nettype wire
